/* rtl/rolling_average_light_level_macros.svh */
// Assertion macros shared by the rolling average light level RTL.
// Each macro expects clk_i and rst_ni to exist in the calling module.
`ifndef ROLLING_AVERAGE_LIGHT_LEVEL_MACROS_SVH
`define ROLLING_AVERAGE_LIGHT_LEVEL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RAL_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ral: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ral: next-cycle check failed");

`endif

/* rtl/ral_pkg.sv */
// Package for the rolling average light level block.
// Types, widths and constants shared by the RTL files that import it; no dependencies.
`timescale 1ns / 1ps

package ral_pkg;

  localparam int SAMPLE_W = 12;
  localparam int IVL_W    = 24;
  localparam int PCT_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_READ_IVL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_IVL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERTED   = 2'd2;

  localparam logic [IVL_W-1:0] IVL_RESET = 24'd10000;
  localparam logic [IVL_W-1:0] IVL_MAX   = 24'hFFFFFF;

  // avg*100/3300 == avg/33; done as avg*3972 >> 17, exact for avg < 32768
  localparam int DIV33_MULT_W = 12;
  localparam logic [DIV33_MULT_W-1:0] DIV33_MULT = 12'd3972;
  localparam int DIV33_SHIFT = 17;
  localparam int PROD_W = SAMPLE_W + DIV33_MULT_W;

  localparam logic [PCT_W-1:0] PCT_SCALE = 8'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } ral_state_e;

endpackage

/* rtl/ral_if.sv */
// Stream channel interfaces for the rolling average light level block.
// Depends on ral_pkg for field widths.
`timescale 1ns / 1ps

interface ral_in_if import ral_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

interface ral_out_if import ral_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PCT_W-1:0]  brightness_pct;
  logic [SAMPLE_W-1:0]      average_mv;

  modport source (output valid, output brightness_pct, output average_mv, input ready);
  modport sink   (input valid, input brightness_pct, input average_mv, output ready);
endinterface

/* rtl/ral_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ral_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ral_div.sv */
// Restoring divider, one quotient bit per cycle, for the window average.
// No package dependencies.
`timescale 1ns / 1ps

module ral_div #(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Remainder always stays below the divisor, so one extra bit suffices
  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/rolling_average_light_level.sv */
// Sequencing: each accepted sample steps through CHECK, then READ, SUM and DIV if a read is
// due, then UPD, and OUT if an update is due; the output register loads in OUT once free.
// A new sample is taken only in IDLE, so the block cannot accept one before the last is
// finished; the bit-serial divider that computes sum / fill count sets the pace.
// Reset: async active low; ring reads as zero until filled, intervals reset to 10000.
// Depends on ral_pkg, ral_if, ral_ram, ral_div and the assertion macro header.
`timescale 1ns / 1ps
`include "rolling_average_light_level_macros.svh"

module rolling_average_light_level import ral_pkg::*; #(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [IVL_W-1:0]     cfg_data_i,
  ral_in_if.sink               in_i,
  ral_out_if.source            out_o
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);

  ral_state_e state_q, state_d;

  logic [IVL_W-1:0]    read_ivl_q, update_ivl_q;
  logic                inverted_q;
  logic [IVL_W-1:0]    since_read_q, since_update_q;
  logic [SAMPLE_W-1:0] mv_q;
  logic [SUM_W-1:0]    sum_q, sum_new;
  logic [SLOT_W-1:0]   slot_q, slot_next;
  logic [FILL_W-1:0]   fill_q, fill_next;
  logic [SAMPLE_W-1:0] avg_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SAMPLE_W-1:0] old_mv;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic                ring_full;
  logic                read_due, update_due;
  logic                in_xfer, out_xfer;
  logic                out_free;
  logic                ram_re, ram_we, div_start, out_load;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic [PCT_W-1:0]    scaled, pct;

  logic                     out_valid_q;
  logic signed [PCT_W-1:0]  pct_out_q;
  logic [SAMPLE_W-1:0]      avg_out_q;

  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign read_due   = since_read_q >= read_ivl_q;
  assign update_due = since_update_q >= update_ivl_q;

  // Before the ring wraps, the write slot points at a never-written entry
  assign ring_full = fill_q >= FILL_W'(WINDOW_DEPTH);
  assign old_mv    = ring_full ? ram_rdata : '0;
  assign sum_new   = sum_q - SUM_W'(old_mv) + SUM_W'(mv_q);
  assign slot_next = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign fill_next = ring_full ? fill_q : fill_q + 1'b1;

  assign scaled = PCT_W'(prod_q[PROD_W-1:DIV33_SHIFT]);
  assign pct    = inverted_q ? (PCT_SCALE - scaled) : scaled;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = ST_CHECK;
      ST_CHECK: state_d = read_due ? ST_READ : ST_UPD;
      ST_READ:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_UPD;
      ST_UPD:   state_d = update_due ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_i.ready = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_i.ready = 1'b1;
      ST_CHECK: ram_re = read_due;
      ST_SUM: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      read_ivl_q     <= IVL_RESET;
      update_ivl_q   <= IVL_RESET;
      inverted_q     <= 1'b1;
      since_read_q   <= '0;
      since_update_q <= '0;
      sum_q          <= '0;
      slot_q         <= '0;
      fill_q         <= '0;
      avg_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_READ_IVL:   read_ivl_q   <= cfg_data_i;
          REG_UPDATE_IVL: update_ivl_q <= cfg_data_i;
          REG_INVERTED:   inverted_q   <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_xfer) begin
        if (since_read_q != IVL_MAX) begin
          since_read_q <= since_read_q + 1'b1;
        end
        if (since_update_q != IVL_MAX) begin
          since_update_q <= since_update_q + 1'b1;
        end
      end

      if (state_q == ST_SUM) begin
        sum_q        <= sum_new;
        slot_q       <= slot_next;
        fill_q       <= fill_next;
        since_read_q <= '0;
      end

      if (state_q == ST_DIV && div_done) begin
        avg_q <= div_quo[SAMPLE_W-1:0];
      end

      if (state_q == ST_UPD && update_due) begin
        since_update_q <= '0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mv_q <= in_i.sample_mv;
    end
    if (state_q == ST_UPD) begin
      prod_q <= PROD_W'(avg_q) * PROD_W'(DIV33_MULT);
    end
    if (out_load) begin
      pct_out_q <= pct;
      avg_out_q <= avg_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.brightness_pct = pct_out_q;
  assign out_o.average_mv     = avg_out_q;

  ral_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (mv_q),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  ral_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (fill_next),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  `RAL_ASSERT_NEXT(a_accept_goes_check, in_xfer, state_q == ST_CHECK)
  `RAL_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_q <= FILL_W'(WINDOW_DEPTH))
  `RAL_ASSERT_IMPLIES(a_slot_tracks_fill, !ring_full, FILL_W'(slot_q) == fill_q)
  `RAL_ASSERT_IMPLIES(a_div_done_in_div, div_done, state_q == ST_DIV)

endmodule
